// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== hdl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Types and constants of the three-wire serial master.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_SETUP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SETUP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW     = 3'd4;

  localparam int TICK_W     = 16;
  localparam int COUNT_W    = 6;
  localparam int INDEX_W    = 5;
  localparam int BYTE_POS_W = COUNT_W + 1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    K_TICK,
    K_LOAD,
    K_START,
    K_NONE
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         cmd_value;
    logic               reading;
    logic [COUNT_W-1:0] count;
    logic               load_ok;
    logic [INDEX_W-1:0] addr;
    logic [7:0]         value;
    logic               pin_in;
  } cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] enable_setup;
    logic [TICK_W-1:0] data_setup;
    logic [TICK_W-1:0] clock_high;
    logic [TICK_W-1:0] clock_low;
    logic [TICK_W-1:0] read_low;
  } cfg_t;

  typedef struct packed {
    logic       enable_pin;
    logic       clock_pin;
    logic       pin_out;
    logic       pin_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_byte;
    logic       busy_res;
    logic       rejected;
  } res_t;

  function automatic logic [TICK_W-1:0] wait_len(input logic [TICK_W-1:0] ticks);
    wait_len = (ticks == '0) ? TICK_W'(1) : ticks;
  endfunction

endpackage

// ===== hdl/tws_if.sv =====
// ----------------------------------------------------------------------------
// tws_in_if / tws_out_if
// Valid-ready channels of the three-wire serial master.
// ----------------------------------------------------------------------------
interface tws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] command_byte;
  logic       read_not_write;
  logic [5:0] byte_count;
  logic [4:0] buffer_index;
  logic [7:0] write_value;
  logic       pin_in;

  modport source (output valid, op, command_byte, read_not_write, byte_count,
                  buffer_index, write_value, pin_in, input ready);
  modport sink (input valid, op, command_byte, read_not_write, byte_count,
                buffer_index, write_value, pin_in, output ready);
endinterface

interface tws_out_if;
  logic       valid;
  logic       ready;
  logic       enable_pin;
  logic       clock_pin;
  logic       pin_out;
  logic       pin_drive;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       last_byte;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, enable_pin, clock_pin, pin_out, pin_drive, read_byte,
                  read_valid, last_byte, busy_res, rejected, input ready);
  modport sink (input valid, enable_pin, clock_pin, pin_out, pin_drive, read_byte,
                read_valid, last_byte, busy_res, rejected, output ready);
endinterface

// ===== hdl/tws_queue.sv =====
// ----------------------------------------------------------------------------
// tws_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tws_queue
  import tws_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/tws_front.sv =====
// ----------------------------------------------------------------------------
// tws_front
// Accepts input transactions and classifies them for the back end.
// ----------------------------------------------------------------------------
module tws_front
  import tws_pkg::*;
#(
  parameter int MAX_BYTES = 32
) (
  tws_in_if.sink item_i,
  input  logic   queue_full_i,
  output logic   push_o,
  output cmd_t   push_data_o
);

  logic [COUNT_W-1:0] count_sat;

  assign item_i.ready = !queue_full_i;
  assign push_o       = item_i.valid && !queue_full_i;

  always_comb begin
    count_sat = item_i.byte_count;
    if (int'(item_i.byte_count) > MAX_BYTES) begin
      count_sat = COUNT_W'(MAX_BYTES);
    end
  end

  always_comb begin
    case (item_i.op)
      OP_TICK:  push_data_o.kind = K_TICK;
      OP_LOAD:  push_data_o.kind = K_LOAD;
      OP_START: push_data_o.kind = K_START;
      default:  push_data_o.kind = K_NONE;
    endcase
    push_data_o.cmd_value = item_i.command_byte | {7'd0, item_i.read_not_write};
    push_data_o.reading   = item_i.read_not_write;
    push_data_o.count     = count_sat;
    push_data_o.load_ok   = (int'(item_i.buffer_index) < MAX_BYTES);
    push_data_o.addr      = item_i.buffer_index;
    push_data_o.value     = item_i.write_value;
    push_data_o.pin_in    = item_i.pin_in;
  end

endmodule

// ===== hdl/tws_back.sv =====
// ----------------------------------------------------------------------------
// tws_back
// Pin sequencer, write buffer and result register.
// ----------------------------------------------------------------------------
module tws_back
  import tws_pkg::*;
#(
  parameter int MAX_BYTES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_valid_i,
  input  cmd_t q_data_i,
  output logic pop_o,
  tws_out_if.source res_o
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_EN_WAIT    = 3'd1;
  localparam logic [2:0] PH_SEND_SETUP = 3'd2;
  localparam logic [2:0] PH_SEND_HIGH  = 3'd3;
  localparam logic [2:0] PH_SEND_LOW   = 3'd4;
  localparam logic [2:0] PH_READ_LOW   = 3'd5;
  localparam logic [2:0] PH_READ_HIGH  = 3'd6;

  logic [7:0] mem [MAX_BYTES];
  logic [7:0] mem_rd_q;
  logic       mem_we;

  logic [2:0]            phase_q, phase_d;
  logic [TICK_W-1:0]     delay_q, delay_d;
  logic [2:0]            bit_q, bit_d;
  logic [BYTE_POS_W-1:0] bpos_q, bpos_d;
  logic [COUNT_W-1:0]    want_q, want_d;
  logic [7:0]            shift_q, shift_d;
  logic [7:0]            cmdv_q, cmdv_d;
  logic                  reading_q, reading_d;
  logic                  en_q, en_d, clk_q, clk_d, dat_q, dat_d, drv_q, drv_d;

  logic       out_v_q;
  res_t       res_q, res_d;
  logic [7:0] next_byte;
  logic       idle;

  assign pop_o = q_valid_i && (!out_v_q || res_o.ready);
  assign idle  = (phase_q == PH_IDLE);
  assign next_byte = (int'(bpos_q) < MAX_BYTES) ? mem_rd_q : 8'd0;

  always_comb begin
    phase_d   = phase_q;
    delay_d   = delay_q;
    bit_d     = bit_q;
    bpos_d    = bpos_q;
    want_d    = want_q;
    shift_d   = shift_q;
    cmdv_d    = cmdv_q;
    reading_d = reading_q;
    en_d      = en_q;
    clk_d     = clk_q;
    dat_d     = dat_q;
    drv_d     = drv_q;
    mem_we    = 1'b0;
    res_d.read_byte  = 8'd0;
    res_d.read_valid = 1'b0;
    res_d.last_byte  = 1'b0;
    res_d.rejected   = 1'b0;

    case (q_data_i.kind)
      K_LOAD: begin
        if (!idle) begin
          res_d.rejected = 1'b1;
        end else begin
          mem_we = q_data_i.load_ok;
        end
      end
      K_START: begin
        if (!idle) begin
          res_d.rejected = 1'b1;
        end else begin
          reading_d = q_data_i.reading;
          cmdv_d    = q_data_i.cmd_value;
          want_d    = q_data_i.count;
          bpos_d    = '0;
          bit_d     = '0;
          shift_d   = '0;
          en_d      = 1'b1;
          clk_d     = 1'b0;
          dat_d     = 1'b0;
          drv_d     = 1'b1;
          phase_d   = PH_EN_WAIT;
          delay_d   = wait_len(cfg_i.enable_setup);
        end
      end
      K_TICK: begin
        if (!idle) begin
          if (delay_q > TICK_W'(1)) begin
            delay_d = delay_q - TICK_W'(1);
          end else begin
            case (phase_q)
              PH_EN_WAIT: begin
                bpos_d  = '0;
                shift_d = cmdv_q;
                bit_d   = '0;
                dat_d   = cmdv_q[0];
                phase_d = PH_SEND_SETUP;
                delay_d = wait_len(cfg_i.data_setup);
              end
              PH_SEND_SETUP: begin
                clk_d   = 1'b1;
                phase_d = PH_SEND_HIGH;
                delay_d = wait_len(cfg_i.clock_high);
              end
              PH_SEND_HIGH: begin
                clk_d   = 1'b0;
                phase_d = PH_SEND_LOW;
                delay_d = wait_len(cfg_i.clock_low);
              end
              PH_SEND_LOW: begin
                if (bit_q != 3'd7) begin
                  bit_d   = bit_q + 3'd1;
                  dat_d   = shift_q[bit_d];
                  phase_d = PH_SEND_SETUP;
                  delay_d = wait_len(cfg_i.data_setup);
                end else begin
                  bpos_d = bpos_q + BYTE_POS_W'(1);
                  if (bpos_d > {1'b0, want_q}) begin
                    en_d    = 1'b0;
                    clk_d   = 1'b0;
                    phase_d = PH_IDLE;
                    delay_d = '0;
                  end else if (reading_q) begin
                    drv_d   = 1'b0;
                    dat_d   = 1'b0;
                    shift_d = '0;
                    bit_d   = '0;
                    phase_d = PH_READ_LOW;
                    delay_d = wait_len(cfg_i.read_low);
                  end else begin
                    shift_d = next_byte;
                    bit_d   = '0;
                    dat_d   = next_byte[0];
                    phase_d = PH_SEND_SETUP;
                    delay_d = wait_len(cfg_i.data_setup);
                  end
                end
              end
              PH_READ_LOW: begin
                clk_d = 1'b1;
                shift_d = shift_q | (8'(q_data_i.pin_in) << bit_q);
                if (bit_q == 3'd7) begin
                  res_d.read_valid = 1'b1;
                  res_d.read_byte  = shift_d;
                  res_d.last_byte  = (bpos_q == {1'b0, want_q});
                  bpos_d           = bpos_q + BYTE_POS_W'(1);
                end
                bit_d   = bit_q + 3'd1;
                phase_d = PH_READ_HIGH;
                delay_d = TICK_W'(1);
              end
              PH_READ_HIGH: begin
                if (bpos_q > {1'b0, want_q}) begin
                  en_d    = 1'b0;
                  clk_d   = 1'b0;
                  phase_d = PH_IDLE;
                  delay_d = '0;
                end else begin
                  clk_d = 1'b0;
                  if (bit_q == 3'd0) begin
                    shift_d = '0;
                  end
                  phase_d = PH_READ_LOW;
                  delay_d = wait_len(cfg_i.read_low);
                end
              end
              default: begin
                en_d    = 1'b0;
                clk_d   = 1'b0;
                phase_d = PH_IDLE;
                delay_d = '0;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase

    res_d.enable_pin = en_d;
    res_d.clock_pin  = clk_d;
    res_d.pin_drive  = drv_d;
    res_d.pin_out    = drv_d && dat_d;
    res_d.busy_res   = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      delay_q   <= '0;
      bit_q     <= '0;
      bpos_q    <= '0;
      want_q    <= '0;
      shift_q   <= '0;
      cmdv_q    <= '0;
      reading_q <= 1'b0;
      en_q      <= 1'b0;
      clk_q     <= 1'b0;
      dat_q     <= 1'b0;
      drv_q     <= 1'b1;
      out_v_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        delay_q   <= delay_d;
        bit_q     <= bit_d;
        bpos_q    <= bpos_d;
        want_q    <= want_d;
        shift_q   <= shift_d;
        cmdv_q    <= cmdv_d;
        reading_q <= reading_d;
        en_q      <= en_d;
        clk_q     <= clk_d;
        dat_q     <= dat_d;
        drv_q     <= drv_d;
        out_v_q   <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  // buffer write and prefetch of the next data byte
  always_ff @(posedge clk_i) begin
    if (pop_o && mem_we) begin
      mem[AW'(q_data_i.addr)] <= q_data_i.value;
    end
    mem_rd_q <= mem[AW'(bpos_q)];
  end

  assign res_o.valid      = out_v_q;
  assign res_o.enable_pin = res_q.enable_pin;
  assign res_o.clock_pin  = res_q.clock_pin;
  assign res_o.pin_out    = res_q.pin_out;
  assign res_o.pin_drive  = res_q.pin_drive;
  assign res_o.read_byte  = res_q.read_byte;
  assign res_o.read_valid = res_q.read_valid;
  assign res_o.last_byte  = res_q.last_byte;
  assign res_o.busy_res   = res_q.busy_res;
  assign res_o.rejected   = res_q.rejected;

endmodule

// ===== hdl/three_wire_serial_master_top.sv =====
// ----------------------------------------------------------------------------
// three_wire_serial_master_top
// Three-wire serial master: enable, clock and bidirectional data pin.
// ----------------------------------------------------------------------------
// channel   dir  handshake     contents
// item_i    in   valid/ready   op, command, count, buffer load, pin sample
// res_o     out  valid/ready   pin levels, received byte, busy, rejected
// cfg       in   write enable  five 16-bit tick registers
//
// one item per clock unless results stall; a result is registered in order in
// the queue entry written at acceptance, then in the result register
// popped tick items count down each phase delay, then step the pin sequencer
// reset clears control state and loads the tick register defaults; no sweep
// a stalled result holds back the queue only, input stays open until it fills
// ----------------------------------------------------------------------------
module three_wire_serial_master_top
  import tws_pkg::*;
#(
  parameter int MAX_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tws_in_if.sink               item_i,
  tws_out_if.source            res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  cfg_t cfg_q;
  logic push, q_full, q_valid, pop;
  cmd_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_setup <= TICK_W'(100);
      cfg_q.data_setup   <= TICK_W'(5);
      cfg_q.clock_high   <= TICK_W'(7);
      cfg_q.clock_low    <= TICK_W'(25);
      cfg_q.read_low     <= TICK_W'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE_SETUP: cfg_q.enable_setup <= cfg_data_i;
        CFG_DATA_SETUP:   cfg_q.data_setup   <= cfg_data_i;
        CFG_CLOCK_HIGH:   cfg_q.clock_high   <= cfg_data_i;
        CFG_CLOCK_LOW:    cfg_q.clock_low    <= cfg_data_i;
        CFG_READ_LOW:     cfg_q.read_low     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tws_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .item_i       (item_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  tws_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  tws_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (pop_data),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule

// ===== hdl/tws_checker.sv =====
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks of the three-wire serial master.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_data_i,
  input logic        enable_pin_i,
  input logic        clock_pin_i,
  input logic        pin_drive_i,
  input logic        read_valid_i,
  input logic        last_byte_i,
  input logic        busy_res_i,
  input logic        rejected_i
);

  // stalled result holds
  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // a received byte completes only with the pin released and the clock just raised
  `ASSERT_IMPLIES(a_read_pins, clk_i, rst_ni, out_valid_i && read_valid_i, busy_res_i && !pin_drive_i && clock_pin_i)

  // only a busy transaction rejects, and last byte comes with a received byte
  `ASSERT_IMPLIES(a_reject_busy, clk_i, rst_ni, out_valid_i && (rejected_i || last_byte_i), (busy_res_i && !last_byte_i) || read_valid_i)

  // enable follows busy and the clock idles low
  `ASSERT_IMPLIES(a_enable_busy, clk_i, rst_ni, out_valid_i, (enable_pin_i == busy_res_i) && (enable_pin_i || !clock_pin_i))

endmodule

bind three_wire_serial_master_top tws_checker u_tws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_data_i   ({res_o.enable_pin, res_o.clock_pin, res_o.pin_out, res_o.pin_drive,
                  res_o.read_byte, res_o.read_valid, res_o.last_byte, res_o.busy_res,
                  res_o.rejected}),
  .enable_pin_i (res_o.enable_pin),
  .clock_pin_i  (res_o.clock_pin),
  .pin_drive_i  (res_o.pin_drive),
  .read_valid_i (res_o.read_valid),
  .last_byte_i  (res_o.last_byte),
  .busy_res_i   (res_o.busy_res),
  .rejected_i   (res_o.rejected)
);
